// ===== design/prescaled_autoreload_timer_defines.svh =====
`ifndef PRESCALED_AUTORELOAD_TIMER_DEFINES_SVH
`define PRESCALED_AUTORELOAD_TIMER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/prt_pkg.sv =====
package prt_pkg;

  localparam int DATA_W      = 16;
  localparam int PRESCALE_W  = 16;
  localparam int CMD_W       = 2;
  localparam int SEL_W       = 3;
  localparam int IN_TUSER_W  = CMD_W + SEL_W;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - 3;

  localparam int CTRL_EN_BIT  = 0;
  localparam int CTRL_OPM_BIT = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [SEL_W-1:0] {
    REG_CTRL   = 3'd0,
    REG_IRQ_EN = 3'd1,
    REG_STATUS = 3'd2,
    REG_UPDGEN = 3'd3,
    REG_COUNT  = 3'd4,
    REG_PSC    = 3'd5,
    REG_RELOAD = 3'd6
  } reg_sel_t;

endpackage

// ===== design/prescaled_autoreload_timer.sv =====
// channel  dir  tdata                                   tuser
// in       in   [15:0] wdata                            [1:0] cmd, [4:2] reg_sel
// out      out  [15:0] rdata, [16] update_flag,         none
//               [17] irq, [18] running, [23:19] zero
// one request per cycle unless out stalls, one result each, single state update stage
// each result is registered in the cycle after its request is taken
// rst_n is synchronous: control clears, reload goes to all ones
// out stall holds the result; in_tready falls only while a held result is not taken
module prescaled_autoreload_timer #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // wdata
  input  logic [4:0]  in_tuser,   // cmd, reg_sel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // rdata, update_flag, irq, running, zero pad
);

  logic                            accept;
  prt_pkg::cmd_t                   cmd;
  logic [prt_pkg::SEL_W-1:0]       sel;
  logic [prt_pkg::DATA_W-1:0]      wdata;

  logic                            en_r, en_nxt;
  logic                            opm_r, opm_nxt;
  logic                            ie_r, ie_nxt;
  logic                            flag_r, flag_nxt;
  logic [COUNT_WIDTH-1:0]          cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0]          arr_r, arr_nxt;
  logic [prt_pkg::PRESCALE_W-1:0]  psc_pre_r, psc_pre_nxt;
  logic [prt_pkg::PRESCALE_W-1:0]  psc_act_r, psc_act_nxt;
  logic [prt_pkg::PRESCALE_W-1:0]  psc_cnt_r, psc_cnt_nxt;
  logic [prt_pkg::DATA_W-1:0]      rdata_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [prt_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  assign cmd    = prt_pkg::cmd_t'(in_tuser[prt_pkg::CMD_W-1:0]);
  assign sel    = in_tuser[prt_pkg::IN_TUSER_W-1:prt_pkg::CMD_W];
  assign wdata  = in_tdata;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    en_nxt      = en_r;
    opm_nxt     = opm_r;
    ie_nxt      = ie_r;
    flag_nxt    = flag_r;
    cnt_nxt     = cnt_r;
    arr_nxt     = arr_r;
    psc_pre_nxt = psc_pre_r;
    psc_act_nxt = psc_act_r;
    psc_cnt_nxt = psc_cnt_r;
    rdata_nxt   = '0;
    case (cmd)
      prt_pkg::CMD_TICK: begin
        if (en_r) begin
          if (psc_cnt_r != psc_act_r) begin
            psc_cnt_nxt = psc_cnt_r + prt_pkg::PRESCALE_W'(1);
          end else begin
            psc_cnt_nxt = '0;
            // zero reload blocks the counter
            if (arr_r != '0) begin
              if (cnt_r == arr_r) begin
                cnt_nxt     = '0;
                psc_act_nxt = psc_pre_r;
                flag_nxt    = 1'b1;
                if (opm_r) begin
                  en_nxt = 1'b0;
                end
              end else begin
                cnt_nxt = cnt_r + COUNT_WIDTH'(1);
              end
            end
          end
        end
      end
      prt_pkg::CMD_WRITE: begin
        case (sel)
          prt_pkg::REG_CTRL: begin
            en_nxt  = wdata[prt_pkg::CTRL_EN_BIT];
            opm_nxt = wdata[prt_pkg::CTRL_OPM_BIT];
          end
          prt_pkg::REG_IRQ_EN: begin
            ie_nxt = wdata[0];
          end
          prt_pkg::REG_STATUS: begin
            if (!wdata[0]) begin
              flag_nxt = 1'b0;
            end
          end
          prt_pkg::REG_UPDGEN: begin
            if (wdata[0]) begin
              cnt_nxt     = '0;
              psc_cnt_nxt = '0;
              psc_act_nxt = psc_pre_r;
              flag_nxt    = 1'b1;
            end
          end
          prt_pkg::REG_COUNT: begin
            cnt_nxt = COUNT_WIDTH'(wdata);
          end
          prt_pkg::REG_PSC: begin
            psc_pre_nxt = wdata;
          end
          prt_pkg::REG_RELOAD: begin
            arr_nxt = COUNT_WIDTH'(wdata);
          end
          default: begin
          end
        endcase
      end
      prt_pkg::CMD_READ: begin
        case (sel)
          prt_pkg::REG_CTRL: begin
            rdata_nxt[prt_pkg::CTRL_EN_BIT]  = en_r;
            rdata_nxt[prt_pkg::CTRL_OPM_BIT] = opm_r;
          end
          prt_pkg::REG_IRQ_EN: begin
            rdata_nxt[0] = ie_r;
          end
          prt_pkg::REG_STATUS: begin
            rdata_nxt[0] = flag_r;
          end
          prt_pkg::REG_COUNT: begin
            rdata_nxt = prt_pkg::DATA_W'(cnt_r);
          end
          prt_pkg::REG_PSC: begin
            rdata_nxt = psc_pre_r;
          end
          prt_pkg::REG_RELOAD: begin
            rdata_nxt = prt_pkg::DATA_W'(arr_r);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_data_nxt = {{prt_pkg::OUT_PAD_W{1'b0}}, en_nxt, flag_nxt && ie_nxt, flag_nxt,
                    rdata_nxt};
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      opm_r       <= 1'b0;
      ie_r        <= 1'b0;
      flag_r      <= 1'b0;
      cnt_r       <= '0;
      arr_r       <= '1;
      psc_pre_r   <= '0;
      psc_act_r   <= '0;
      psc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        en_r      <= en_nxt;
        opm_r     <= opm_nxt;
        ie_r      <= ie_nxt;
        flag_r    <= flag_nxt;
        cnt_r     <= cnt_nxt;
        arr_r     <= arr_nxt;
        psc_pre_r <= psc_pre_nxt;
        psc_act_r <= psc_act_nxt;
        psc_cnt_r <= psc_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== design/prt_checker.sv =====
`include "prescaled_autoreload_timer_defines.svh"

module prt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [4:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  logic in_acc;
  logic is_read;
  logic is_updgen;
  logic out_flag;
  logic out_irq;
  logic rdata_zero;
  logic held;

  assign in_acc     = in_tvalid && in_tready;
  assign is_read    = in_tuser[1:0] == prt_pkg::CMD_READ;
  assign is_updgen  = in_tuser[1:0] == prt_pkg::CMD_WRITE &&
                      in_tuser[4:2] == prt_pkg::REG_UPDGEN && in_tdata[0];
  assign out_flag   = out_tdata[16];
  assign out_irq    = out_tdata[17];
  assign rdata_zero = out_tdata[15:0] == 16'd0;
  assign held       = out_tvalid && !out_tready;

  // irq only ever shows together with the update flag
  `PRT_ASSERT_NOW(a_irq_needs_flag, out_tvalid && out_irq, out_flag, "irq without flag")

  // non-read requests return zero read data in the next result
  `PRT_ASSERT_NEXT(a_rdata_zero, in_acc && !is_read, out_tvalid && rdata_zero, "rdata nonzero")

  // forced update always shows the flag set in its result
  `PRT_ASSERT_NEXT(a_updgen_flag, in_acc && is_updgen, out_tvalid && out_flag, "forced update lost")

  // a stalled result stays put
  `PRT_ASSERT_NEXT(a_out_hold, held, out_tvalid && $stable(out_tdata), "result dropped")

endmodule

bind prescaled_autoreload_timer prt_checker u_prt_checker (.*);

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [prt_pkg::SEL_W-1:0] SEL_UNUSED = 3'd7;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 125;
  localparam int SETTLE_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 400;

  typedef struct packed {
    logic [prt_pkg::DATA_W-1:0] rdata;
    logic                       flag;
    logic                       irq;
    logic                       running;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [15:0] in_tdata;
  logic [4:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;

  // timer state as seen by the predictor
  logic tmr_en;
  logic tmr_opm;
  logic tmr_uie;
  logic tmr_uif;
  logic [prt_pkg::DATA_W-1:0] tmr_cnt;
  logic [prt_pkg::PRESCALE_W-1:0] psc_shadow;
  logic [prt_pkg::PRESCALE_W-1:0] psc_live;
  logic [prt_pkg::PRESCALE_W-1:0] psc_div;
  logic [prt_pkg::DATA_W-1:0] tmr_arr;

  timer_result_t result_q[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;

  prescaled_autoreload_timer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void timer_clear();
    tmr_en = 1'b0;
    tmr_opm = 1'b0;
    tmr_uie = 1'b0;
    tmr_uif = 1'b0;
    tmr_cnt = '0;
    psc_shadow = '0;
    psc_live = '0;
    psc_div = '0;
    tmr_arr = '1;
  endfunction

  function automatic void timer_update_event();
    psc_live = psc_shadow;
    tmr_uif = 1'b1;
  endfunction

  function automatic timer_result_t timer_step(prt_pkg::cmd_t c,
                                               logic [prt_pkg::SEL_W-1:0] s,
                                               logic [15:0] d);
    timer_result_t r;
    r = '0;
    case (c)
      prt_pkg::CMD_TICK: begin
        if (tmr_en) begin
          if (psc_div != psc_live) begin
            psc_div = psc_div + 1'b1;
          end else begin
            psc_div = '0;
            if (tmr_arr != '0) begin
              if (tmr_cnt == tmr_arr) begin
                tmr_cnt = '0;
                timer_update_event();
                if (tmr_opm) tmr_en = 1'b0;
              end else begin
                tmr_cnt = tmr_cnt + 1'b1;
              end
            end
          end
        end
      end
      prt_pkg::CMD_WRITE: begin
        case (s)
          prt_pkg::REG_CTRL: begin
            tmr_en = d[prt_pkg::CTRL_EN_BIT];
            tmr_opm = d[prt_pkg::CTRL_OPM_BIT];
          end
          prt_pkg::REG_IRQ_EN: tmr_uie = d[0];
          prt_pkg::REG_STATUS: if (!d[0]) tmr_uif = 1'b0;
          prt_pkg::REG_UPDGEN: begin
            if (d[0]) begin
              tmr_cnt = '0;
              psc_div = '0;
              timer_update_event();
            end
          end
          prt_pkg::REG_COUNT: tmr_cnt = d;
          prt_pkg::REG_PSC: psc_shadow = d;
          prt_pkg::REG_RELOAD: tmr_arr = d;
          default: ;
        endcase
      end
      prt_pkg::CMD_READ: begin
        case (s)
          prt_pkg::REG_CTRL: begin
            r.rdata[prt_pkg::CTRL_EN_BIT] = tmr_en;
            r.rdata[prt_pkg::CTRL_OPM_BIT] = tmr_opm;
          end
          prt_pkg::REG_IRQ_EN: r.rdata[0] = tmr_uie;
          prt_pkg::REG_STATUS: r.rdata[0] = tmr_uif;
          prt_pkg::REG_COUNT: r.rdata = tmr_cnt;
          prt_pkg::REG_PSC: r.rdata = psc_shadow;
          prt_pkg::REG_RELOAD: r.rdata = tmr_arr;
          default: ;
        endcase
      end
      default: ;
    endcase
    r.flag = tmr_uif;
    r.irq = tmr_uif & tmr_uie;
    r.running = tmr_en;
    return r;
  endfunction

  task automatic send_request(prt_pkg::cmd_t c, logic [prt_pkg::SEL_W-1:0] s,
                              logic [15:0] d);
    int gap;
    gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= {s, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    result_q.push_back(timer_step(c, s, d));
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_wdata(logic [prt_pkg::SEL_W-1:0] s);
    logic [15:0] d;
    d = 16'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      case (s)
        prt_pkg::REG_CTRL: d[prt_pkg::CTRL_EN_BIT] = 1'b1;
        prt_pkg::REG_COUNT, prt_pkg::REG_RELOAD: d = 16'($urandom_range(0, 12));
        prt_pkg::REG_PSC: d = 16'($urandom_range(0, 3));
        default: ;
      endcase
    end
    return d;
  endfunction

  task automatic send_random_request();
    int r;
    logic [prt_pkg::SEL_W-1:0] s;
    logic [15:0] d;
    r = $urandom_range(0, 99);
    s = 3'($urandom_range(0, 7));
    d = pick_wdata(s);
    if (r < 60) send_request(prt_pkg::CMD_TICK, s, 16'($urandom));
    else if (r < 75) send_request(prt_pkg::CMD_READ, s, 16'($urandom));
    else if (r < 96) send_request(prt_pkg::CMD_WRITE, s, d);
    else send_request(prt_pkg::CMD_NOP, s, 16'($urandom));
  endtask

  task automatic test_register_access();
    send_request(prt_pkg::CMD_READ, prt_pkg::REG_RELOAD, 16'h0000);
    send_request(prt_pkg::CMD_NOP, SEL_UNUSED, 16'hffff);
    send_request(prt_pkg::CMD_WRITE, SEL_UNUSED, 16'hffff);
    send_request(prt_pkg::CMD_READ, SEL_UNUSED, 16'h0000);
    send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_IRQ_EN, 16'hffff);
    send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_CTRL, 16'hfff6);
    send_request(prt_pkg::CMD_READ, prt_pkg::REG_CTRL, 16'h0000);
    send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_UPDGEN, 16'hffff);
    send_request(prt_pkg::CMD_READ, prt_pkg::REG_UPDGEN, 16'h0000);
    send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_STATUS, 16'hffff);
    send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_STATUS, 16'hfffe);
    send_request(prt_pkg::CMD_READ, prt_pkg::REG_STATUS, 16'h0000);
  endtask

  task automatic test_update_events();
    // prescale of two, wrap after one count, one-pulse stop
    send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_PSC, 16'h0001);
    send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_RELOAD, 16'h0001);
    send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_UPDGEN, 16'h0001);
    send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_STATUS, 16'h0000);
    send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_CTRL, 16'h0009);
    repeat (5) send_request(prt_pkg::CMD_TICK, prt_pkg::REG_CTRL, 16'h0000);
    // blocked counter with zero reload
    send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_RELOAD, 16'h0000);
    send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_CTRL, 16'h0001);
    repeat (2) send_request(prt_pkg::CMD_TICK, prt_pkg::REG_CTRL, 16'h0000);
    // counter above reload rolls over without an update
    send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_COUNT, 16'hffff);
    send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_RELOAD, 16'h0002);
    repeat (2) send_request(prt_pkg::CMD_TICK, prt_pkg::REG_CTRL, 16'h0000);
    send_request(prt_pkg::CMD_READ, prt_pkg::REG_COUNT, 16'h0000);
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < PHASES; p++) begin
      steady = (p % 4 == 1);
      send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_PSC, 16'($urandom_range(0, 3)));
      send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_RELOAD, 16'($urandom_range(0, 8)));
      send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_UPDGEN, 16'h0001);
      send_request(prt_pkg::CMD_WRITE, prt_pkg::REG_CTRL,
                   16'((1 << prt_pkg::CTRL_EN_BIT) |
                       ($urandom_range(0, 1) << prt_pkg::CTRL_OPM_BIT)));
      repeat (PHASE_ITEMS - 4) send_random_request();
      if (p == PHASES / 2) wait_results_drained();
    end
    steady = 1'b0;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    timer_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $realtime, out_tdata);
      end else begin
        want = result_q.pop_front();
        check_field("rdata", int'(want.rdata), int'(out_tdata[15:0]));
        check_field("update_flag", int'(want.flag), int'(out_tdata[16]));
        check_field("irq", int'(want.irq), int'(out_tdata[17]));
        check_field("running", int'(want.running), int'(out_tdata[18]));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    timer_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_update_events();
    test_random_traffic();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
